FILE: rtl/core/psced_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psced_pkg
// Shared types and constants for the panel state-change event decoder.
// ----------------------------------------------------------------------------
package psced_pkg;

	// slider positions accepted: 0 .. LEVEL_COUNT-1
	localparam int unsigned LEVEL_COUNT = 16;
	localparam logic [8:0]  LEVEL_LIMIT = 9'(LEVEL_COUNT);

	localparam logic [7:0] HEADER_MARK   = 8'h0A;
	localparam logic [7:0] TRAILER_MARK  = 8'h00;
	localparam logic [7:0] CODE_IDLE     = 8'h00;
	localparam logic [7:0] CODE_TOUCH    = 8'h01;
	localparam logic [7:0] CODE_HELD     = 8'h02;
	localparam logic [7:0] CODE_RELEASE  = 8'h03;
	localparam logic [7:0] SLIDE_RELEASE = 8'h02;

	localparam logic [1:0] PART_POWER  = 2'd0;
	localparam logic [1:0] PART_COLOUR = 2'd1;
	localparam logic [1:0] PART_SLIDER = 2'd2;

	localparam logic [1:0] ACT_TOUCH   = 2'd0;
	localparam logic [1:0] ACT_RELEASE = 2'd1;
	localparam logic [1:0] ACT_UNKNOWN = 2'd2;

	typedef struct packed {
		logic [7:0] header_byte;
		logic [7:0] power_code;
		logic [7:0] colour_code;
		logic [7:0] slide_code;
		logic [7:0] slide_position;
		logic [7:0] trailer_byte;
	} report_t;

	typedef struct packed {
		logic       accepted;
		logic       has_event;
		logic [1:0] panel_part;
		logic [1:0] panel_action;
		logic       level_valid;
		logic [4:0] slide_level;
	} result_t;

endpackage

FILE: rtl/core/psced_report_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psced_report_if / psced_result_if
// Valid/ready channels for panel reports and decoded results.
// ----------------------------------------------------------------------------
interface psced_report_if import psced_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] header_byte;
	logic [7:0] power_code;
	logic [7:0] colour_code;
	logic [7:0] slide_code;
	logic [7:0] slide_position;
	logic [7:0] trailer_byte;

	modport source (
		output valid, header_byte, power_code, colour_code, slide_code,
		       slide_position, trailer_byte,
		input  ready
	);
	modport sink (
		input  valid, header_byte, power_code, colour_code, slide_code,
		       slide_position, trailer_byte,
		output ready
	);
endinterface

interface psced_result_if import psced_pkg::*; ();
	logic       valid;
	logic       ready;
	logic       accepted;
	logic       has_event;
	logic [1:0] panel_part;
	logic [1:0] panel_action;
	logic       level_valid;
	logic [4:0] slide_level;

	modport source (
		output valid, accepted, has_event, panel_part, panel_action,
		       level_valid, slide_level,
		input  ready
	);
	modport sink (
		input  valid, accepted, has_event, panel_part, panel_action,
		       level_valid, slide_level,
		output ready
	);
endinterface

FILE: rtl/core/panel_state_change_event_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// panel_state_change_event_decoder
// Decodes full-state touch panel reports into at most one change event.
//
//   channel  | dir | beat contents
//   ---------+-----+---------------------------------------------------
//   report   | in  | header, power/colour/slide codes, position, trailer
//   result   | out | accepted, has_event, part, action, level
//
// One report per cycle sustained while the result side keeps taking results.
// Input register feeds the decode logic, result register holds the answer.
// Reset clears both valid flags and the stored panel state to zero.
// A stalled result holds the pipe; report.ready drops only when the input
// register is full and the result register cannot drain.
// ----------------------------------------------------------------------------
module panel_state_change_event_decoder import psced_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	psced_report_if.sink          report,
	psced_result_if.source        result
);

	logic    valid_s1;
	report_t rep_s1;
	logic    res_valid_q;
	result_t res_q;
	result_t res_next;
	logic    advance;
	logic    fire;

	assign advance      = !res_valid_q || result.ready;
	assign fire         = valid_s1 && advance;
	assign report.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (report.ready) begin
			valid_s1 <= report.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (report.ready && report.valid) begin
			rep_s1.header_byte    <= report.header_byte;
			rep_s1.power_code     <= report.power_code;
			rep_s1.colour_code    <= report.colour_code;
			rep_s1.slide_code     <= report.slide_code;
			rep_s1.slide_position <= report.slide_position;
			rep_s1.trailer_byte   <= report.trailer_byte;
		end
	end

	psced_eval u_eval (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.rep    (rep_s1),
		.res    (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res_next;
		end
	end

	assign result.valid        = res_valid_q;
	assign result.accepted     = res_q.accepted;
	assign result.has_event    = res_q.has_event;
	assign result.panel_part   = res_q.panel_part;
	assign result.panel_action = res_q.panel_action;
	assign result.level_valid  = res_q.level_valid;
	assign result.slide_level  = res_q.slide_level;

	a_result_from_stage: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(valid_s1))
		else $error("result appeared without a decoded report");

	a_full_pipe_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && res_valid_q && !result.ready |-> !report.ready)
		else $error("report taken while pipe is blocked");

	a_event_accepted: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.has_event |-> res_q.accepted)
		else $error("event flagged on a rejected report");

endmodule

FILE: rtl/core/psced_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psced_eval
// Framing check, change detection and event priority; holds the last well-framed report.
// ----------------------------------------------------------------------------
module psced_eval import psced_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  report_t rep,
	output result_t res
);

	logic [7:0] prev_power_q;
	logic [7:0] prev_colour_q;
	logic [7:0] prev_slide_code_q;
	logic [7:0] prev_slide_position_q;

	logic       frame_ok;
	logic       col_ch;
	logic       pwr_ch;
	logic       sl_ch;
	logic [7:0] btn_code;
	logic [1:0] btn_part;
	logic [8:0] level_sum;

	function automatic logic button_moved(input logic [7:0] now, input logic [7:0] last);
		logic moved;
		moved = (now != last) &&
			((now != CODE_IDLE) || (last == CODE_TOUCH) || (last == CODE_HELD));
		return moved;
	endfunction

	assign frame_ok = (rep.header_byte == HEADER_MARK) &&
		(rep.trailer_byte == TRAILER_MARK) &&
		({1'b0, rep.slide_position} < LEVEL_LIMIT);

	assign col_ch = button_moved(rep.colour_code, prev_colour_q);
	assign pwr_ch = button_moved(rep.power_code, prev_power_q);
	assign sl_ch  = ((rep.slide_code != prev_slide_code_q) ||
		(rep.slide_position != prev_slide_position_q)) && (rep.slide_code != CODE_IDLE);

	// colour wins over power
	assign btn_code  = col_ch ? rep.colour_code : rep.power_code;
	assign btn_part  = col_ch ? PART_COLOUR : PART_POWER;
	assign level_sum = {1'b0, rep.slide_position} + 9'd1;

	always_comb begin
		res = '0;
		if (frame_ok) begin
			if (col_ch || pwr_ch) begin
				unique case (btn_code)
					CODE_TOUCH: begin
						res.accepted     = 1'b1;
						res.has_event    = 1'b1;
						res.panel_part   = btn_part;
						res.panel_action = ACT_TOUCH;
					end
					CODE_HELD: begin
						res.accepted     = 1'b1;
						res.has_event    = 1'b1;
						res.panel_part   = btn_part;
						res.panel_action = ACT_UNKNOWN;
					end
					CODE_IDLE, CODE_RELEASE: begin
						res.accepted     = 1'b1;
						res.has_event    = 1'b1;
						res.panel_part   = btn_part;
						res.panel_action = ACT_RELEASE;
					end
					default: begin
						// unknown code: reject, state still updates
					end
				endcase
			end else if (sl_ch) begin
				if (rep.slide_code == CODE_TOUCH) begin
					res.accepted     = 1'b1;
					res.has_event    = 1'b1;
					res.panel_part   = PART_SLIDER;
					res.panel_action = ACT_TOUCH;
					res.level_valid  = 1'b1;
					res.slide_level  = level_sum[4:0];
				end else if (rep.slide_code == SLIDE_RELEASE) begin
					res.accepted     = 1'b1;
					res.has_event    = 1'b1;
					res.panel_part   = PART_SLIDER;
					res.panel_action = ACT_RELEASE;
				end
			end else begin
				res.accepted = 1'b1;
			end
		end
	end

	// keep the last well-framed report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_power_q          <= '0;
			prev_colour_q         <= '0;
			prev_slide_code_q     <= '0;
			prev_slide_position_q <= '0;
		end else if (fire && frame_ok) begin
			prev_power_q          <= rep.power_code;
			prev_colour_q         <= rep.colour_code;
			prev_slide_code_q     <= rep.slide_code;
			prev_slide_position_q <= rep.slide_position;
		end
	end

	a_bad_frame_holds: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !frame_ok |=> $stable(prev_power_q) && $stable(prev_colour_q) &&
			$stable(prev_slide_code_q) && $stable(prev_slide_position_q))
		else $error("state changed on a rejected frame");

	a_event_needs_accept: assert property (@(posedge clk) disable iff (!arst_n)
		res.has_event |-> res.accepted && frame_ok)
		else $error("event without accepted frame");

	a_level_only_slider: assert property (@(posedge clk) disable iff (!arst_n)
		res.level_valid |-> res.panel_part == PART_SLIDER && res.panel_action == ACT_TOUCH)
		else $error("level on non-slider-touch event");

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the panel state-change event decoder.
// Sends framed and broken panel reports, tracks the last well-framed panel state
// on the side and checks every decoded result in order. It covers the sender
// and receiver idling in turn, and one long receiver stall.
// ----------------------------------------------------------------------------
module tb;
	import psced_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;

	psced_report_if rpt ();
	psced_result_if res ();

	panel_state_change_event_decoder i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.report (rpt),
		.result (res)
	);

	// panel state as the decoder should hold it
	logic [7:0] last_power;
	logic [7:0] last_colour;
	logic [7:0] last_slide_code;
	logic [7:0] last_slide_pos;

	result_t pending_results[$];
	report_t last_sent;

	int src_idle_pct;
	int snk_idle_pct;
	int hold_req;
	int stall_left;
	int cycle_count;
	int errors;
	int reports_sent;
	int results_seen;
	int rejects_seen;
	int quiet_seen;
	int part_events[3];

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic bit btn_moved(logic [7:0] now, logic [7:0] was);
		if (now == was)
			return 1'b0;
		return now != CODE_IDLE || was == CODE_TOUCH || was == CODE_HELD;
	endfunction

	function automatic result_t decode_report(report_t r);
		result_t    d;
		bit         colour_ch;
		bit         power_ch;
		bit         slide_ch;
		logic [7:0] code;
		d = '0;
		if (r.header_byte == HEADER_MARK && r.trailer_byte == TRAILER_MARK &&
		    int'(r.slide_position) < LEVEL_COUNT) begin
			colour_ch = btn_moved(r.colour_code, last_colour);
			power_ch  = btn_moved(r.power_code, last_power);
			slide_ch  = (r.slide_code != last_slide_code ||
			             r.slide_position != last_slide_pos) &&
			            r.slide_code != CODE_IDLE;
			last_power      = r.power_code;
			last_colour     = r.colour_code;
			last_slide_code = r.slide_code;
			last_slide_pos  = r.slide_position;
			if (colour_ch || power_ch) begin
				code = colour_ch ? r.colour_code : r.power_code;
				d.panel_part = colour_ch ? PART_COLOUR : PART_POWER;
				case (code)
					CODE_TOUCH: begin
						d.accepted = 1'b1;
						d.has_event = 1'b1;
						d.panel_action = ACT_TOUCH;
					end
					CODE_HELD: begin
						d.accepted = 1'b1;
						d.has_event = 1'b1;
						d.panel_action = ACT_UNKNOWN;
					end
					CODE_IDLE, CODE_RELEASE: begin
						d.accepted = 1'b1;
						d.has_event = 1'b1;
						d.panel_action = ACT_RELEASE;
					end
					default: d.panel_part = PART_POWER;
				endcase
			end else if (slide_ch) begin
				if (r.slide_code == CODE_TOUCH) begin
					d.accepted = 1'b1;
					d.has_event = 1'b1;
					d.panel_part = PART_SLIDER;
					d.panel_action = ACT_TOUCH;
					d.level_valid = 1'b1;
					d.slide_level = 5'(int'(r.slide_position) + 1);
				end else if (r.slide_code == SLIDE_RELEASE) begin
					d.accepted = 1'b1;
					d.has_event = 1'b1;
					d.panel_part = PART_SLIDER;
					d.panel_action = ACT_RELEASE;
				end
			end else begin
				d.accepted = 1'b1;
			end
		end
		return d;
	endfunction

	function automatic report_t mk(logic [7:0] hdr, logic [7:0] pwr, logic [7:0] col,
	                               logic [7:0] sc, logic [7:0] sp, logic [7:0] trl);
		report_t r;
		r.header_byte    = hdr;
		r.power_code     = pwr;
		r.colour_code    = col;
		r.slide_code     = sc;
		r.slide_position = sp;
		r.trailer_byte   = trl;
		return r;
	endfunction

	function automatic logic [7:0] pick_code(logic [7:0] keep, int top);
		if ($urandom_range(1) == 0)
			return keep;
		if ($urandom_range(9) == 0)
			return 8'($urandom_range(255));
		return 8'($urandom_range(top));
	endfunction

	// mostly well-framed reports that wander from the last one, some noise
	function automatic report_t random_report();
		report_t r;
		if ($urandom_range(99) < 88) begin
			r.header_byte    = HEADER_MARK;
			r.trailer_byte   = TRAILER_MARK;
			r.power_code     = pick_code(last_sent.power_code, 3);
			r.colour_code    = pick_code(last_sent.colour_code, 3);
			r.slide_code     = pick_code(last_sent.slide_code, 2);
			r.slide_position = ($urandom_range(1) == 0) ? last_sent.slide_position :
			                   8'($urandom_range(LEVEL_COUNT - 1));
			if (int'(r.slide_position) >= LEVEL_COUNT)
				r.slide_position = 8'($urandom_range(LEVEL_COUNT - 1));
		end else begin
			r.header_byte    = $urandom_range(1) ? HEADER_MARK : 8'($urandom_range(255));
			r.trailer_byte   = $urandom_range(1) ? TRAILER_MARK : 8'($urandom_range(255));
			r.power_code     = 8'($urandom_range(255));
			r.colour_code    = 8'($urandom_range(255));
			r.slide_code     = 8'($urandom_range(255));
			r.slide_position = 8'($urandom_range(255));
		end
		return r;
	endfunction

	// call at a rising edge; returns at the edge that took the beat, or after a gap
	task automatic send_report(report_t r);
		rpt.valid          <= 1'b1;
		rpt.header_byte    <= r.header_byte;
		rpt.power_code     <= r.power_code;
		rpt.colour_code    <= r.colour_code;
		rpt.slide_code     <= r.slide_code;
		rpt.slide_position <= r.slide_position;
		rpt.trailer_byte   <= r.trailer_byte;
		do @(posedge clk); while (rpt.ready !== 1'b1);
		pending_results.push_back(decode_report(r));
		last_sent = r;
		reports_sent++;
		if ($urandom_range(99) < src_idle_pct) begin
			rpt.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < src_idle_pct)
				@(posedge clk);
		end
	endtask

	task automatic drain();
		rpt.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic test_framing();
		send_report(mk(8'h0B, CODE_TOUCH, CODE_IDLE, CODE_IDLE, 8'd0, TRAILER_MARK));
		send_report(mk(8'hF5, CODE_TOUCH, CODE_IDLE, CODE_IDLE, 8'd0, TRAILER_MARK));
		send_report(mk(HEADER_MARK, CODE_TOUCH, CODE_IDLE, CODE_IDLE, 8'd0, 8'h80));
		send_report(mk(HEADER_MARK, CODE_TOUCH, CODE_IDLE, CODE_IDLE, 8'd0, 8'h7F));
		send_report(mk(HEADER_MARK, CODE_TOUCH, CODE_IDLE, CODE_TOUCH,
		               8'(LEVEL_COUNT), TRAILER_MARK));
		send_report(mk(HEADER_MARK, CODE_TOUCH, CODE_IDLE, CODE_TOUCH, 8'hFF, TRAILER_MARK));
		// state must still be idle, so this one is a power touch
		send_report(mk(HEADER_MARK, CODE_TOUCH, CODE_IDLE, CODE_IDLE, 8'd0, TRAILER_MARK));
	endtask

	task automatic test_buttons();
		send_report(mk(HEADER_MARK, CODE_HELD, CODE_IDLE, CODE_IDLE, 8'd0, TRAILER_MARK));
		send_report(mk(HEADER_MARK, CODE_IDLE, CODE_IDLE, CODE_IDLE, 8'd0, TRAILER_MARK));
		send_report(mk(HEADER_MARK, CODE_RELEASE, CODE_IDLE, CODE_IDLE, 8'd0, TRAILER_MARK));
		// idle after release is no change
		send_report(mk(HEADER_MARK, CODE_IDLE, CODE_IDLE, CODE_IDLE, 8'd0, TRAILER_MARK));
		send_report(mk(HEADER_MARK, CODE_TOUCH, CODE_TOUCH, CODE_IDLE, 8'd0, TRAILER_MARK));
		send_report(mk(HEADER_MARK, CODE_TOUCH, CODE_IDLE, CODE_IDLE, 8'd0, TRAILER_MARK));
		// unknown codes reject the beat but still land in the state
		send_report(mk(HEADER_MARK, 8'h04, CODE_IDLE, CODE_IDLE, 8'd0, TRAILER_MARK));
		send_report(mk(HEADER_MARK, 8'h04, CODE_IDLE, CODE_IDLE, 8'd0, TRAILER_MARK));
		send_report(mk(HEADER_MARK, 8'h04, 8'hFF, CODE_IDLE, 8'd0, TRAILER_MARK));
		send_report(mk(HEADER_MARK, CODE_IDLE, CODE_IDLE, CODE_IDLE, 8'd0, TRAILER_MARK));
	endtask

	task automatic test_slider();
		send_report(mk(HEADER_MARK, CODE_IDLE, CODE_IDLE, CODE_TOUCH, 8'd0, TRAILER_MARK));
		send_report(mk(HEADER_MARK, CODE_IDLE, CODE_IDLE, CODE_TOUCH,
		               8'(LEVEL_COUNT - 1), TRAILER_MARK));
		send_report(mk(HEADER_MARK, CODE_IDLE, CODE_IDLE, CODE_TOUCH,
		               8'(LEVEL_COUNT - 1), TRAILER_MARK));
		send_report(mk(HEADER_MARK, CODE_IDLE, CODE_IDLE, SLIDE_RELEASE, 8'd3, TRAILER_MARK));
		send_report(mk(HEADER_MARK, CODE_IDLE, CODE_IDLE, CODE_IDLE, 8'd3, TRAILER_MARK));
		send_report(mk(HEADER_MARK, CODE_IDLE, CODE_IDLE, 8'h03, 8'd3, TRAILER_MARK));
		send_report(mk(HEADER_MARK, CODE_IDLE, CODE_IDLE, 8'hFF, 8'd7, TRAILER_MARK));
		// power wins over a slider move in the same beat
		send_report(mk(HEADER_MARK, CODE_TOUCH, CODE_IDLE, CODE_TOUCH, 8'd5, TRAILER_MARK));
	endtask

	task automatic test_random(int src_pct, int snk_pct, int count);
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		repeat (count)
			send_report(random_report());
		drain();
	endtask

	task automatic test_backpressure();
		src_idle_pct = 0;
		snk_idle_pct = 0;
		hold_req = 80;
		repeat (40)
			send_report(random_report());
		// pause until the decoder has handed back everything
		drain();
	endtask

	task automatic check_field(string name, logic [4:0] want, logic [4:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && res.valid === 1'b1 && res.ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result beat with no report outstanding", $time);
				errors++;
			end else begin
				want = pending_results.pop_front();
				check_field("accepted", 5'(want.accepted), 5'(res.accepted));
				check_field("has_event", 5'(want.has_event), 5'(res.has_event));
				check_field("panel_part", 5'(want.panel_part), 5'(res.panel_part));
				check_field("panel_action", 5'(want.panel_action), 5'(res.panel_action));
				check_field("level_valid", 5'(want.level_valid), 5'(res.level_valid));
				check_field("slide_level", want.slide_level, res.slide_level);
				results_seen++;
				if (!want.accepted)
					rejects_seen++;
				else if (!want.has_event)
					quiet_seen++;
				else
					part_events[want.panel_part]++;
			end
		end
		if (hold_req != 0) begin
			stall_left = hold_req;
			hold_req = 0;
		end
		if (stall_left > 0) begin
			stall_left--;
			res.ready <= 1'b0;
		end else begin
			res.ready <= arst_n && ($urandom_range(99) >= snk_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		rpt.valid = 1'b0;
		rpt.header_byte = '0;
		rpt.power_code = '0;
		rpt.colour_code = '0;
		rpt.slide_code = '0;
		rpt.slide_position = '0;
		rpt.trailer_byte = '0;
		res.ready = 1'b0;
		last_power = '0;
		last_colour = '0;
		last_slide_code = '0;
		last_slide_pos = '0;
		last_sent = mk(HEADER_MARK, CODE_IDLE, CODE_IDLE, CODE_IDLE, 8'd0, TRAILER_MARK);
		src_idle_pct = 0;
		snk_idle_pct = 0;
		hold_req = 0;
		stall_left = 0;
		cycle_count = 0;
		errors = 0;
		reports_sent = 0;
		results_seen = 0;
		rejects_seen = 0;
		quiet_seen = 0;
		part_events = '{0, 0, 0};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_framing();
		test_buttons();
		test_slider();
		drain();
		test_random(18, 81, 400);
		test_random(81, 18, 400);
		test_backpressure();
		test_random(0, 0, 400);

		repeat (8) @(posedge clk);
		$display("covered %0d reports, %0d results: %0d rejected, %0d without event",
		         reports_sent, results_seen, rejects_seen, quiet_seen);
		$display("events by part: power %0d, colour %0d, slider %0d; one long output stall",
		         part_events[0], part_events[1], part_events[2]);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
